/* rtl/lrupr_pkg.sv */
// Shared types, constants and helpers for the LRU page replacement unit.
package lrupr_pkg;

   // Field widths fixed by the interface
   localparam int PAGE_W     = 12;
   localparam int OFFSET_W   = 21;
   localparam int COUNT_W    = 32;
   localparam int NF_W       = 5;
   localparam int NP_W       = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // Defaults and limits
   localparam int FRAMES_DEFAULT = 16;
   localparam int PAGE_LIMIT     = 4096;

   // Register reset values
   localparam logic [NF_W-1:0]     NUM_FRAMES_RESET   = NF_W'(16);
   localparam logic [NP_W-1:0]     NUM_PAGES_RESET    = NP_W'(4096);
   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT_RESET = OFFSET_W'(4096);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_FRAMES   = 2'd0,
      CSR_NUM_PAGES    = 2'd1,
      CSR_OFFSET_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      STS_HIT        = 3'd0,
      STS_FILL       = 3'd1,
      STS_EVICT      = 3'd2,
      STS_BAD_PAGE   = 3'd3,
      STS_BAD_OFFSET = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   // Update command broadcast to every frame cell
   typedef struct packed {
      logic update;
      logic fill;
      logic evict;
   } cell_ctl_type;

   // Bits needed for a frame index or a recency rank
   function automatic int rank_width(input int frames);
      return (frames > 1) ? $clog2(frames) : 1;
   endfunction

endpackage

/* rtl/lrupr_cell.sv */
// One frame cell: resident page, recency rank, tag compare and hit priority link.
module lrupr_cell import lrupr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT,
   parameter int RANK_W = rank_width(FRAMES_DEFAULT)
) (
   input  logic              clock,
   input  logic              compare_en,
   input  logic [PAGE_W-1:0] lookup_page,
   input  logic [PAGE_W-1:0] new_page,
   input  logic              in_use,
   input  logic              first_in,
   output logic              first_out,
   output logic              hit_here,
   input  cell_ctl_type      ctl,
   input  logic              target,
   input  logic [RANK_W-1:0] sel_rank,
   output logic [RANK_W-1:0] rank,
   output logic [PAGE_W-1:0] page
);

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

   logic [PAGE_W-1:0] page_ff, page_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              match_ff, match_in;
   logic              match;

   // tag compare is captured when the item is taken
   assign match_in = compare_en ? (page_ff == lookup_page) : match_ff;

   // lowest matching frame wins; the link ripples up the row
   assign match     = match_ff & in_use;
   assign hit_here  = match & ~first_in;
   assign first_out = first_in | match;

   // rank and page update
   always_comb begin
      rank_in = rank_ff;
      page_in = page_ff;
      if (ctl.update) begin
         if (target) begin
            rank_in = '0;
            if (ctl.fill || ctl.evict) begin
               page_in = new_page;
            end
         end else if (in_use) begin
            if (ctl.fill) begin
               if (rank_ff != RANK_MAX) begin
                  rank_in = rank_ff + RANK_W'(1);
               end
            end else if (rank_ff < sel_rank) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      rank_ff  <= rank_in;
      match_ff <= match_in;
   end

   assign rank = rank_ff;
   assign page = page_ff;

endmodule

/* rtl/lrupr_victim.sv */
// Victim picker: lowest-numbered in-use frame holding the greatest recency rank.
module lrupr_victim import lrupr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT,
   parameter int RANK_W = rank_width(FRAMES_DEFAULT)
) (
   input  logic [FRAMES-1:0][RANK_W-1:0] ranks,
   input  logic [FRAMES-1:0]             in_use,
   output logic [FRAMES-1:0]             victim_sel,
   output logic [RANK_W-1:0]             max_rank
);

   logic [FRAMES-1:0] cand;
   logic [FRAMES-1:0] bit_set;

   // bitwise max search, MSB first: one OR reduction per rank bit
   always_comb begin
      cand     = in_use;
      bit_set  = '0;
      max_rank = '0;
      for (int b = RANK_W - 1; b >= 0; b--) begin
         for (int i = 0; i < FRAMES; i++) begin
            bit_set[i] = cand[i] & ranks[i][b];
         end
         max_rank[b] = |bit_set;
         if (|bit_set) begin
            cand = bit_set;
         end
      end
   end

   // isolate lowest remaining candidate
   assign victim_sel = cand & (~cand + FRAMES'(1));

endmodule

/* rtl/lru_page_replacement.sv */
// Top level of the LRU page replacement unit.
//
// Usage:
//   Pulse start with req_page_number / req_word_offset while busy is low; the
//   item is taken at that clock edge. busy is high in the cycle after it.
//   The result shows on the rsp_ ports for one cycle with rsp_valid high, in the
//   cycle after busy.
//   A new item may be started in the same cycle the previous result is shown;
//   no new item is taken while busy is high.
//   On accept, each frame cell compares its page against the request. Then, while
//   busy: priority pick of the hit, bitwise max-rank victim search across the row,
//   and the rank/page update in every cell; the result is registered.
//   Configuration: csr_write with csr_index and csr_data, taken at once;
//   write only while no item is in flight. Indexes outside the list are
//   ignored.
//   Reset (synchronous, active high) empties all frames, clears the fault and
//   access counters and restores default configuration. No clearing pass.
//   The receiver cannot stall: each result is valid for one cycle only.
module lru_page_replacement import lrupr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT,
   localparam int FRAME_W = rank_width(FRAMES)
) (
   input  logic                  clock,
   input  logic                  reset,
   // item request
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_W-1:0]     req_page_number,
   input  logic [OFFSET_W-1:0]   req_word_offset,
   // result
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [FRAME_W-1:0]    rsp_frame_number,
   output logic [OFFSET_W-1:0]   rsp_offset_out,
   output logic [PAGE_W-1:0]     rsp_evicted_page,
   output logic [COUNT_W-1:0]    rsp_fault_count,
   output logic [COUNT_W-1:0]    rsp_access_count,
   // configuration
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int CMP_W = (CNT_W > NF_W) ? CNT_W : NF_W;

   // control state
   state_type state_ff, state_in;
   logic [NF_W-1:0]     num_frames_ff, num_frames_in;
   logic [NP_W-1:0]     num_pages_ff, num_pages_in;
   logic [OFFSET_W-1:0] offset_limit_ff, offset_limit_in;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   logic [COUNT_W-1:0]  faults_ff, faults_in;
   logic [COUNT_W-1:0]  accesses_ff, accesses_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [PAGE_W-1:0]   req_page_ff, req_page_in;
   logic [OFFSET_W-1:0] req_offset_ff, req_offset_in;
   logic                err_ff, err_in;
   status_type          err_status_ff, err_status_in;

   // result payload
   status_type          rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [PAGE_W-1:0]   rsp_evicted_ff, rsp_evicted_in;
   logic [COUNT_W-1:0]  rsp_faults_ff, rsp_faults_in;
   logic [COUNT_W-1:0]  rsp_accesses_ff, rsp_accesses_in;

   logic accept, eval;
   logic bad_page, bad_offset;
   logic [CMP_W-1:0] nf_wide, cap_wide;
   logic [CNT_W-1:0] cap, used;
   logic has_free;

   logic [FRAMES-1:0]             in_use, hit_vec, fill_vec, victim_sel, target_vec;
   logic [FRAMES:0]               first_chain;
   logic [FRAMES-1:0][FRAME_W-1:0] cell_rank;
   logic [FRAMES-1:0][PAGE_W-1:0]  cell_page;
   logic [FRAME_W-1:0]            max_rank, hit_rank, sel_rank, frame_idx;
   logic [PAGE_W-1:0]             victim_page;
   logic                          hit_any;
   cell_ctl_type                  cell_ctl;

   // state machine: next state and handshake
   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      eval     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            busy     = 1'b1;
            eval     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = start & ~busy;

   // configuration writes
   always_comb begin
      num_frames_in   = num_frames_ff;
      num_pages_in    = num_pages_ff;
      offset_limit_in = offset_limit_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_FRAMES:   num_frames_in   = csr_data[NF_W-1:0];
            CSR_NUM_PAGES:    num_pages_in    = csr_data[NP_W-1:0];
            CSR_OFFSET_LIMIT: offset_limit_in = csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // request checks, captured with the item
   assign bad_page   = (NP_W'(req_page_number) >= num_pages_ff)
                    || (32'(req_page_number) >= 32'(PAGE_LIMIT));
   assign bad_offset = (req_word_offset == '0) || (req_word_offset > offset_limit_ff);

   always_comb begin
      req_page_in   = req_page_ff;
      req_offset_in = req_offset_ff;
      err_in        = err_ff;
      err_status_in = err_status_ff;
      if (accept) begin
         req_page_in   = req_page_number;
         req_offset_in = req_word_offset;
         err_in        = bad_page | bad_offset;
         err_status_in = bad_page ? STS_BAD_PAGE : STS_BAD_OFFSET;
      end
   end

   // capacity clamp and frames in use
   assign nf_wide  = CMP_W'(num_frames_ff);
   assign cap_wide = (nf_wide == '0) ? CMP_W'(1) :
                     (nf_wide > CMP_W'(FRAMES)) ? CMP_W'(FRAMES) : nf_wide;
   assign cap      = cap_wide[CNT_W-1:0];
   assign used     = (filled_ff < cap) ? filled_ff : cap;
   assign has_free = used < cap;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         in_use[i]   = CNT_W'(i) < used;
         fill_vec[i] = CNT_W'(i) == used;
      end
   end

   // frame cell row
   assign first_chain[0] = 1'b0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lrupr_cell #(
         .FRAMES (FRAMES),
         .RANK_W (FRAME_W)
      ) u_cell (
         .clock       (clock),
         .compare_en  (accept),
         .lookup_page (req_page_number),
         .new_page    (req_page_ff),
         .in_use      (in_use[g]),
         .first_in    (first_chain[g]),
         .first_out   (first_chain[g+1]),
         .hit_here    (hit_vec[g]),
         .ctl         (cell_ctl),
         .target      (target_vec[g]),
         .sel_rank    (sel_rank),
         .rank        (cell_rank[g]),
         .page        (cell_page[g])
      );
   end

   assign hit_any = first_chain[FRAMES];

   lrupr_victim #(
      .FRAMES (FRAMES),
      .RANK_W (FRAME_W)
   ) u_victim (
      .ranks      (cell_rank),
      .in_use     (in_use),
      .victim_sel (victim_sel),
      .max_rank   (max_rank)
   );

   // update command for the row
   always_comb begin
      cell_ctl.update = eval & ~err_ff;
      cell_ctl.fill   = ~hit_any & has_free;
      cell_ctl.evict  = ~hit_any & ~has_free;
      if (hit_any) begin
         target_vec = hit_vec;
      end else if (has_free) begin
         target_vec = fill_vec;
      end else begin
         target_vec = victim_sel;
      end
   end

   // one-hot selects to indexes and values
   always_comb begin
      frame_idx   = '0;
      hit_rank    = '0;
      victim_page = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (target_vec[i]) begin
            frame_idx = frame_idx | FRAME_W'(i);
         end
         if (hit_vec[i]) begin
            hit_rank = hit_rank | cell_rank[i];
         end
         if (victim_sel[i]) begin
            victim_page = victim_page | cell_page[i];
         end
      end
   end

   assign sel_rank = hit_any ? hit_rank : max_rank;

   // counters and fill level
   always_comb begin
      filled_in   = filled_ff;
      faults_in   = faults_ff;
      accesses_in = accesses_ff;
      if (cell_ctl.update) begin
         if (accesses_ff != '1) begin
            accesses_in = accesses_ff + COUNT_W'(1);
         end
         if (!hit_any && faults_ff != '1) begin
            faults_in = faults_ff + COUNT_W'(1);
         end
         if (cell_ctl.fill) begin
            filled_in = used + CNT_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = eval;
      rsp_status_in   = rsp_status_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_faults_in   = rsp_faults_ff;
      rsp_accesses_in = rsp_accesses_ff;
      if (eval) begin
         rsp_offset_in   = req_offset_ff;
         rsp_faults_in   = faults_in;
         rsp_accesses_in = accesses_in;
         if (err_ff) begin
            rsp_status_in  = err_status_ff;
            rsp_frame_in   = '0;
            rsp_evicted_in = '0;
         end else begin
            rsp_frame_in = frame_idx;
            if (hit_any) begin
               rsp_status_in  = STS_HIT;
               rsp_evicted_in = '0;
            end else if (has_free) begin
               rsp_status_in  = STS_FILL;
               rsp_evicted_in = '0;
            end else begin
               rsp_status_in  = STS_EVICT;
               rsp_evicted_in = victim_page;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_frames_ff   <= NUM_FRAMES_RESET;
         num_pages_ff    <= NUM_PAGES_RESET;
         offset_limit_ff <= OFFSET_LIMIT_RESET;
         filled_ff       <= '0;
         faults_ff       <= '0;
         accesses_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         num_frames_ff   <= num_frames_in;
         num_pages_ff    <= num_pages_in;
         offset_limit_ff <= offset_limit_in;
         filled_ff       <= filled_in;
         faults_ff       <= faults_in;
         accesses_ff     <= accesses_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_page_ff     <= req_page_in;
      req_offset_ff   <= req_offset_in;
      err_ff          <= err_in;
      err_status_ff   <= err_status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_faults_ff   <= rsp_faults_in;
      rsp_accesses_ff <= rsp_accesses_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_offset_out   = rsp_offset_ff;
   assign rsp_evicted_page = rsp_evicted_ff;
   assign rsp_fault_count  = rsp_faults_ff;
   assign rsp_access_count = rsp_accesses_ff;

`ifndef NO_ASSERTIONS
   // every taken item is answered with rsp_valid after its evaluation cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("item result missing two cycles after accept");

   // a result only follows an evaluation cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EVAL))
      else $error("result without evaluation");

   // an update touches exactly one target frame
   a_target_onehot: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.update |-> $onehot(target_vec))
      else $error("update target not one-hot");

   // fill level moves only on a fill into a free frame
   a_filled_step: assert property (@(posedge clock) disable iff (reset)
      (filled_ff != $past(filled_ff)) |-> $past(cell_ctl.update && cell_ctl.fill))
      else $error("fill level changed without a fill");

   // error results carry no frame and no evicted page
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STS_BAD_PAGE || rsp_status == STS_BAD_OFFSET))
      |-> (rsp_frame_number == '0 && rsp_evicted_page == '0))
      else $error("error result with nonzero frame or page");
`endif

endmodule

/* tb/lru_translation_checker.sv */
// Checker for the LRU page replacement unit: tracks frames and ranks, predicts and compares.
`timescale 1ns / 100ps

module lru_translation_checker import lrupr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT,
   localparam int FRAME_W = rank_width(FRAMES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [PAGE_W-1:0]     req_page_number,
   input  logic [OFFSET_W-1:0]   req_word_offset,
   input  logic                  rsp_valid,
   input  logic [2:0]            rsp_status,
   input  logic [FRAME_W-1:0]    rsp_frame_number,
   input  logic [OFFSET_W-1:0]   rsp_offset_out,
   input  logic [PAGE_W-1:0]     rsp_evicted_page,
   input  logic [COUNT_W-1:0]    rsp_fault_count,
   input  logic [COUNT_W-1:0]    rsp_access_count,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    pending
);

   // keep the log readable when the block is badly off
   localparam int REPORT_MAX = 200;

   typedef struct packed {
      status_type           status;
      logic [FRAME_W-1:0]   frame;
      logic [OFFSET_W-1:0]  offset;
      logic [PAGE_W-1:0]    evicted;
      logic [COUNT_W-1:0]   faults;
      logic [COUNT_W-1:0]   accesses;
   } translation_type;

   // configuration copy
   logic [NF_W-1:0]     frames_in_use;
   logic [NP_W-1:0]     page_count;
   logic [OFFSET_W-1:0] page_bytes;

   // frame table copy
   logic [PAGE_W-1:0]   frame_page [FRAMES];
   logic [FRAME_W-1:0]  frame_rank [FRAMES];
   int                  filled;
   logic [COUNT_W-1:0]  fault_total;
   logic [COUNT_W-1:0]  access_total;

   translation_type expected_translations [$];

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // move frame f to most recent among the first count frames
   function automatic void promote(input int f, input int count);
      logic [FRAME_W-1:0] r;
      r = frame_rank[f];
      for (int i = 0; i < count; i++) begin
         if (i != f && frame_rank[i] < r) frame_rank[i] = frame_rank[i] + 1'b1;
      end
      frame_rank[f] = '0;
   endfunction

   function automatic translation_type translate_access(input logic [PAGE_W-1:0] page,
                                                        input logic [OFFSET_W-1:0] off);
      translation_type t;
      int cap;
      int used;
      int slot;
      bit hit;
      t = '0;
      t.offset = off;
      // bad page wins over a bad offset
      if ({1'b0, page} >= page_count || int'(page) >= PAGE_LIMIT) begin
         t.status = STS_BAD_PAGE;
      end else if (off == '0 || off > page_bytes) begin
         t.status = STS_BAD_OFFSET;
      end else begin
         cap = int'(frames_in_use);
         if (cap < 1) cap = 1;
         if (cap > FRAMES) cap = FRAMES;
         used = (filled < cap) ? filled : cap;
         hit = 1'b0;
         slot = 0;
         // lowest frame holding the page answers
         for (int i = 0; i < used; i++) begin
            if (!hit && frame_page[i] == page) begin
               hit = 1'b1;
               slot = i;
            end
         end
         if (hit) begin
            t.status = STS_HIT;
            promote(slot, used);
         end else if (used < cap) begin
            // fill the next free frame, everyone else ages
            t.status = STS_FILL;
            slot = used;
            for (int i = 0; i < used; i++) begin
               if (frame_rank[i] < FRAMES - 1) frame_rank[i] = frame_rank[i] + 1'b1;
            end
            frame_page[slot] = page;
            frame_rank[slot] = '0;
            filled = used + 1;
            fault_total = bump(fault_total);
         end else begin
            // victim: lowest frame of greatest rank
            t.status = STS_EVICT;
            slot = 0;
            for (int i = 1; i < used; i++) begin
               if (frame_rank[i] > frame_rank[slot]) slot = i;
            end
            t.evicted = frame_page[slot];
            frame_page[slot] = page;
            promote(slot, used);
            fault_total = bump(fault_total);
         end
         t.frame = FRAME_W'(slot);
         access_total = bump(access_total);
      end
      t.faults = fault_total;
      t.accesses = access_total;
      return t;
   endfunction

   task automatic compare_field(input string field, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         frames_in_use = NUM_FRAMES_RESET;
         page_count = NUM_PAGES_RESET;
         page_bytes = OFFSET_LIMIT_RESET;
         filled = 0;
         fault_total = '0;
         access_total = '0;
         mismatches = 0;
         expected_translations.delete();
      end else begin
         // register writes; unlisted indexes are dropped
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_FRAMES:   frames_in_use = csr_data[NF_W-1:0];
               CSR_NUM_PAGES:    page_count = csr_data[NP_W-1:0];
               CSR_OFFSET_LIMIT: page_bytes = csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
         // result leaving the block belongs to the oldest item
         if (rsp_valid) begin
            if (expected_translations.size() == 0) begin
               mismatches++;
               $error("result with no item outstanding");
            end else begin
               want = expected_translations.pop_front();
               compare_field("status", COUNT_W'(want.status), COUNT_W'(rsp_status));
               compare_field("frame_number", COUNT_W'(want.frame), COUNT_W'(rsp_frame_number));
               compare_field("offset_out", COUNT_W'(want.offset), COUNT_W'(rsp_offset_out));
               compare_field("evicted_page", COUNT_W'(want.evicted),
                             COUNT_W'(rsp_evicted_page));
               compare_field("fault_count", want.faults, rsp_fault_count);
               compare_field("access_count", want.accesses, rsp_access_count);
            end
         end
         // item taken into the block
         if (start && !busy)
            expected_translations.push_back(translate_access(req_page_number, req_word_offset));
      end
      pending = expected_translations.size();
   end

endmodule

/* tb/tb_lru_page_replacement.sv */
// Testbench top for the LRU page replacement unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_lru_page_replacement import lrupr_pkg::*;;

   localparam int FRAMES = FRAMES_DEFAULT;
   localparam int FRAME_W = rank_width(FRAMES);
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 204;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int OFFSET_MAX = (1 << OFFSET_W) - 1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PAGE_W-1:0]     req_page_number;
   logic [OFFSET_W-1:0]   req_word_offset;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic [FRAME_W-1:0]    rsp_frame_number;
   logic [OFFSET_W-1:0]   rsp_offset_out;
   logic [PAGE_W-1:0]     rsp_evicted_page;
   logic [COUNT_W-1:0]    rsp_fault_count;
   logic [COUNT_W-1:0]    rsp_access_count;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    mismatches;
   int                    pending;
   int                    quiet_cycles;

   // current settings, used to shape the stimulus
   int cfg_frames;
   int cfg_pages;
   int cfg_limit;

   lru_page_replacement #(.FRAMES(FRAMES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page_number  (req_page_number),
      .req_word_offset  (req_word_offset),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_frame_number (rsp_frame_number),
      .rsp_offset_out   (rsp_offset_out),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_count  (rsp_fault_count),
      .rsp_access_count (rsp_access_count),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   lru_translation_checker #(.FRAMES(FRAMES)) CHECK (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page_number  (req_page_number),
      .req_word_offset  (req_word_offset),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_frame_number (rsp_frame_number),
      .rsp_offset_out   (rsp_offset_out),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_count  (rsp_fault_count),
      .rsp_access_count (rsp_access_count),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: nothing taken and nothing returned for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL lru_page_replacement");
            $finish;
         end
      end
   end

   // present one item and hold it until the block takes it; returns at a falling edge
   task automatic send_access(input int page, input int off);
      start <= 1'b1;
      req_page_number <= PAGE_W'(page);
      req_word_offset <= OFFSET_W'(off);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // wait until every item has come back
   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // write all registers while idle; the spare index gets junk
   task automatic program_regs(input int frames, input int pages, input int limit);
      logic [CSR_DATA_W-1:0] data;
      drain();
      cfg_frames = frames;
      cfg_pages = pages;
      cfg_limit = limit;
      data = CSR_DATA_W'($urandom);
      data[NF_W-1:0] = NF_W'(frames);
      csr_write <= 1'b1;
      csr_index <= CSR_NUM_FRAMES;
      csr_data <= data;
      @(negedge clock);
      data = CSR_DATA_W'($urandom);
      data[NP_W-1:0] = NP_W'(pages);
      csr_index <= CSR_NUM_PAGES;
      csr_data <= data;
      @(negedge clock);
      csr_index <= CSR_OFFSET_LIMIT;
      csr_data <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_data <= CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int page_span;
      int cap;
      int base;
      int roll;
      int idle_pct;
      int page;
      int off;
      reset = 1'b1;
      start = 1'b0;
      req_page_number = '0;
      req_word_offset = '0;
      csr_write = 1'b0;
      csr_index = CSR_NUM_FRAMES;
      csr_data = '0;
      cfg_frames = 16;
      cfg_pages = 4096;
      cfg_limit = 4096;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default settings after reset
      send_access(0, 1);           // fill, smallest offset
      send_access(4095, 4096);     // fill, top page, offset at the limit
      send_access(0, 4097);        // offset just past the limit
      send_access(0, 0);           // zero offset
      send_access(4095, 0);
      send_access(0, 2000);        // hit
      // two frames: evictions pick the older page
      program_regs(2, 4096, 4096);
      send_access(7, 5);
      send_access(4095, 1);
      // zero frames behaves as one
      program_regs(0, 4096, 4096);
      send_access(9, 3);
      send_access(9, 4);
      // frame count above the maximum, page count above the page space
      program_regs(31, 8191, OFFSET_MAX);
      send_access(4095, OFFSET_MAX);
      send_access(3, 1048576);
      // bad page takes priority over a bad offset
      program_regs(16, 10, 1);
      send_access(10, 0);
      send_access(9, 1);
      send_access(9, 2);
      // no pages and zero-byte pages
      program_regs(16, 0, 0);
      send_access(0, 1);
      program_regs(16, 1, 0);
      send_access(0, 1);
      // shrink the frame set, then grow it back so a page sits in two frames
      program_regs(16, 4096, 4096);
      send_access(100, 8);
      send_access(101, 8);
      send_access(102, 8);
      send_access(103, 8);
      program_regs(2, 4096, 4096);
      send_access(103, 9);
      program_regs(16, 4096, 4096);
      send_access(103, 10);
      send_access(101, 11);

      // random phases, the extremes first
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_regs(1, 4096, 1048576);
            1: program_regs(16, 4096, 4096);
            2: program_regs(0, 8191, OFFSET_MAX);
            3: program_regs(31, 1, 1);
            default: begin
               program_regs(($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                         : $urandom_range(0, 31),
                            ($urandom_range(0, 99) < 75) ? $urandom_range(1, 300)
                                                         : $urandom_range(0, 8191),
                            ($urandom_range(0, 99) < 60) ? $urandom_range(1, 8192)
                                                         : $urandom_range(0, OFFSET_MAX));
            end
         endcase
         page_span = (cfg_pages < 1) ? 1 : ((cfg_pages > PAGE_LIMIT) ? PAGE_LIMIT : cfg_pages);
         cap = (cfg_frames < 1) ? 1 : ((cfg_frames > FRAMES) ? FRAMES : cfg_frames);
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         if (p == PHASES - 1) idle_pct = 0;
         base = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // a working set a little larger than the frames, moved now and then
            if (k % 48 == 0) base = $urandom_range(0, page_span - 1);
            page = (base + $urandom_range(0, cap + 3)) % page_span;
            off = (cfg_limit < 1) ? 1 : $urandom_range(1, cfg_limit);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               page = $urandom_range(0, PAGE_LIMIT - 1);
               off = $urandom_range(0, OFFSET_MAX);
            end else if (roll < 12) begin
               off = 0;
            end else if (roll < 16) begin
               off = (cfg_limit < OFFSET_MAX) ? cfg_limit + 1 : 0;
            end else if (roll < 19) begin
               page = (cfg_pages < PAGE_LIMIT) ? $urandom_range(cfg_pages, PAGE_LIMIT - 1)
                                               : $urandom_range(0, PAGE_LIMIT - 1);
            end
            send_access(page, off);
            if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 17));
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS lru_page_replacement");
      end else begin
         $display("FAIL lru_page_replacement");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lrupr_victim.sv
rtl/lru_page_replacement.sv
tb/lru_translation_checker.sv
tb/tb_lru_page_replacement.sv
